@@ sv/dog_pkg.sv @@
package dog_pkg;

	localparam int EXP_TABLE_BITS = 10;
	localparam int TBL_SIZE       = (1 << EXP_TABLE_BITS) + 1;
	localparam int FILL_W         = EXP_TABLE_BITS + 1;
	localparam int SH             = 16 - EXP_TABLE_BITS;
	localparam int TW             = 31;
	localparam int EVEN_DEPTH     = (1 << (EXP_TABLE_BITS - 1)) + 1;
	localparam int ODD_DEPTH      = 1 << (EXP_TABLE_BITS - 1);
	localparam int SERIES_TERMS   = 16;

	localparam logic [63:0] LOG2E_Q30        = 64'd1549082005;
	localparam logic [63:0] LN2_Q30          = 64'd744261118;
	localparam logic [63:0] INV_SQRT_2PI_Q32 = 64'd1713444047;
	localparam logic [63:0] ONE_Q30          = 64'd1 << 30;

	// pipeline depth, final stage is the output register
	localparam int NSTAGE = 55;

	localparam logic [2:0] REG_MODE    = 3'd0;
	localparam logic [2:0] REG_MEAN1   = 3'd1;
	localparam logic [2:0] REG_SIGMA1  = 3'd2;
	localparam logic [2:0] REG_MEAN2   = 3'd3;
	localparam logic [2:0] REG_SIGMA2  = 3'd4;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last_in;
	} in_t;

	typedef struct packed {
		logic signed [31:0] density;
		logic               last_out;
	} out_t;

	typedef logic [NSTAGE:1] stg_t;

	typedef struct packed {
		logic                      we_even;
		logic                      we_odd;
		logic [EXP_TABLE_BITS-1:0] addr;
		logic [TW-1:0]             data;
	} fill_t;

	typedef logic [TW-1:0] tbl_t [TBL_SIZE];

	// 2^(-k/2^B) in Q30 from a truncated alternating series of exp(-y)
	function automatic tbl_t build_tbl();
		tbl_t        tbl;
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		for (int k = 0; k < TBL_SIZE; k++) begin
			y    = (64'(k) * LN2_Q30) >> EXP_TABLE_BITS;
			term = ONE_Q30;
			pos  = ONE_Q30;
			neg  = '0;
			for (int n = 1; n < SERIES_TERMS; n++) begin
				term = ((term * y) >> 30) / 64'(n);
				if (n % 2 == 1) begin
					neg = neg + term;
				end else begin
					pos = pos + term;
				end
			end
			tbl[k] = (pos >= neg) ? TW'(pos - neg) : '0;
		end
		return tbl;
	endfunction

	localparam tbl_t EXP_TBL = build_tbl();

endpackage

@@ sv/difference_of_gaussians_eval_core.sv @@
// Gaussian / difference-of-Gaussians evaluator.
// in channel: in_valid/in_ready, in_data carries a signed Q8.8 sample and a
// last flag. out channel: out_valid/out_ready, out_data carries the signed
// Q16.16 density and the copied last flag. One result beat per input beat,
// in order.
// Config: cfg_we/cfg_addr/cfg_wdata, write only, no wait state. Write while
// the pipeline is empty; mode 0 gives g1(x), mode 1 gives g1(x) - g2(x).
// Throughput: one result beat per cycle is sustained while out_ready stays
// high. The depth comes from two bit-per-stage dividers, by 2 sigma^2 and
// by sigma, plus the table read and multiplier stages.
// Reset: registers take their defaults, then the exponential table is copied
// into the lane memories, with in_ready low until the whole table is written.
// Stall: a full stage holds while its successor is full and held; bubbles
// close up, so input is taken while a result waits, until no stage is empty.
module difference_of_gaussians_eval_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dog_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output dog_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_addr,
	input  logic [15:0]   cfg_wdata
);
	import dog_pkg::*;

	logic        mode_q;
	logic [15:0] mean1_q;
	logic [15:0] sigma1_q;
	logic [15:0] mean2_q;
	logic [15:0] sigma2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			mean1_q  <= 16'd0;
			sigma1_q <= 16'd256;
			mean2_q  <= 16'd0;
			sigma2_q <= 16'd512;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MODE:   mode_q   <= cfg_wdata[0];
				REG_MEAN1:  mean1_q  <= cfg_wdata;
				REG_SIGMA1: sigma1_q <= cfg_wdata;
				REG_MEAN2:  mean2_q  <= cfg_wdata;
				REG_SIGMA2: sigma2_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// table load after reset
	logic [FILL_W-1:0] fill_q;
	logic              filled;
	logic [FILL_W-1:0] fidx;
	fill_t             fill;

	assign filled = fill_q == FILL_W'(TBL_SIZE);
	assign fidx   = filled ? '0 : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (!filled) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_comb begin
		fill.we_even = !filled && !fill_q[0];
		fill.we_odd  = !filled && fill_q[0];
		fill.addr    = fill_q[FILL_W-1:1];
		fill.data    = EXP_TBL[fidx];
	end

	// stage control
	stg_t rdy;
	stg_t vld_q;

	always_comb begin
		rdy[NSTAGE] = !vld_q[NSTAGE] || out_ready;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign in_ready = rdy[1] && filled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= in_valid && filled;
			end
			for (int k = 2; k <= NSTAGE; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	logic last_s [1:NSTAGE];

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			last_s[1] <= in_data.last_in;
		end
		for (int k = 2; k <= NSTAGE; k++) begin
			if (rdy[k]) begin
				last_s[k] <= last_s[k-1];
			end
		end
	end

	logic [22:0] mag1;
	logic [22:0] mag2;

	dog_lane u_lane1 (
		.clk   (clk),
		.en    (rdy),
		.x     (in_data.sample),
		.mean  (mean1_q),
		.sigma (sigma1_q),
		.fill  (fill),
		.mag   (mag1)
	);

	dog_lane u_lane2 (
		.clk   (clk),
		.en    (rdy),
		.x     (in_data.sample),
		.mean  (mean2_q),
		.sigma (sigma2_q),
		.fill  (fill),
		.mag   (mag2)
	);

	// output stage: combine; result always fits Q16.16
	logic signed [24:0] v;
	logic signed [31:0] dens_s55;

	assign v = $signed({2'b00, mag1}) - (mode_q ? $signed({2'b00, mag2}) : 25'sd0);

	always_ff @(posedge clk) begin
		if (rdy[NSTAGE]) begin
			dens_s55 <= 32'(v);
		end
	end

	assign out_valid         = vld_q[NSTAGE];
	assign out_data.density  = dens_s55;
	assign out_data.last_out = last_s[NSTAGE];

endmodule

@@ sv/dog_ram.sv @@
module dog_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/dog_lane.sv @@
module dog_lane (
	input  logic                 clk,
	input  dog_pkg::stg_t        en,
	input  logic signed [15:0]   x,
	input  logic [15:0]          mean,
	input  logic [15:0]          sigma,
	input  dog_pkg::fill_t       fill,
	output logic [22:0]          mag
);
	import dog_pkg::*;

	localparam int EAW = $clog2(EVEN_DEPTH);
	localparam int OAW = $clog2(ODD_DEPTH);

	logic [15:0] s_q;
	logic [32:0] den_q;

	always_ff @(posedge clk) begin
		s_q   <= (sigma == 16'd0) ? 16'd1 : sigma;
		den_q <= {32'(s_q) * 32'(s_q), 1'b0};
	end

	// stage 1, 2: |x - mean|, square
	logic signed [16:0] d;
	logic [15:0]        ad_s1;
	logic [31:0]        sq_s2;

	assign d = 17'(x) - 17'($signed(mean));

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ad_s1 <= d[16] ? 16'(-d) : d[15:0];
		end
		if (en[2]) begin
			sq_s2 <= ad_s1 * ad_s1;
		end
	end

	// stage 3 .. 25: (sq << 16) / den, quotient bits 21..0, overflow flagged
	logic [47:0] d1_rem_s [0:22];
	logic [21:0] d1_q_s   [0:22];
	logic        d1_ov_s  [0:22];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			d1_rem_s[0] <= {sq_s2, 16'd0};
			d1_q_s[0]   <= '0;
			d1_ov_s[0]  <= {7'd0, sq_s2} >= {den_q, 6'd0};
		end
	end

	for (genvar j = 0; j < 22; j++) begin : g_div1
		logic [54:0] dsh;
		logic        ge;
		assign dsh = 55'(den_q) << (21 - j);
		assign ge  = {7'd0, d1_rem_s[j]} >= dsh;
		always_ff @(posedge clk) begin
			if (en[4+j]) begin
				d1_rem_s[j+1] <= ge ? d1_rem_s[j] - dsh[47:0] : d1_rem_s[j];
				d1_q_s[j+1]   <= d1_q_s[j] | (22'(ge) << (21 - j));
				d1_ov_s[j+1]  <= d1_ov_s[j];
			end
		end
	end

	// stage 26: clamp and scale to base 2
	logic [21:0] t;
	logic [52:0] tu;
	logic [21:0] u_s26;

	assign t  = (d1_ov_s[22] || d1_q_s[22] > 22'(1 << 21)) ? 22'(1 << 21) : d1_q_s[22];
	assign tu = 53'(t) * 53'(LOG2E_Q30[30:0]);

	always_ff @(posedge clk) begin
		if (en[26]) begin
			u_s26 <= tu[51:30];
		end
	end

	// stage 27: table read, even and odd banks give T[i] and T[i+1]
	logic [EXP_TABLE_BITS-1:0] ti;
	logic [EAW-1:0]            ev_ra;
	logic [OAW-1:0]            od_ra;
	logic [TW-1:0]             ev_rd;
	logic [TW-1:0]             od_rd;
	logic [5:0]                ui_s27;
	logic [SH-1:0]             r_s27;
	logic                      par_s27;

	assign ti    = u_s26[15:SH];
	assign ev_ra = EAW'(ti >> 1) + EAW'(ti[0]);
	assign od_ra = OAW'(ti >> 1);

	dog_ram #(.WIDTH(TW), .DEPTH(EVEN_DEPTH)) u_even (
		.clk   (clk),
		.we    (fill.we_even),
		.waddr (EAW'(fill.addr)),
		.wdata (fill.data),
		.re    (en[27]),
		.raddr (ev_ra),
		.rdata (ev_rd)
	);

	dog_ram #(.WIDTH(TW), .DEPTH(ODD_DEPTH)) u_odd (
		.clk   (clk),
		.we    (fill.we_odd),
		.waddr (OAW'(fill.addr)),
		.wdata (fill.data),
		.re    (en[27]),
		.raddr (od_ra),
		.rdata (od_rd)
	);

	always_ff @(posedge clk) begin
		if (en[27]) begin
			ui_s27  <= u_s26[21:16];
			r_s27   <= u_s26[SH-1:0];
			par_s27 <= ti[0];
		end
	end

	// stage 28 .. 30: interpolate, then shift by integer part
	logic [TW-1:0]    ta;
	logic [TW-1:0]    tb;
	logic [TW-1:0]    a_s28;
	logic [TW-1:0]    diff_s28;
	logic             dec_s28;
	logic [SH-1:0]    r_s28;
	logic [5:0]       ui_s28;
	logic [TW+SH-1:0] stp;
	logic [TW-1:0]    e_s29;
	logic [5:0]       ui_s29;
	logic [TW-1:0]    g_s30;

	assign ta  = par_s27 ? od_rd : ev_rd;
	assign tb  = par_s27 ? ev_rd : od_rd;
	assign stp = (TW+SH)'(diff_s28) * (TW+SH)'(r_s28);

	always_ff @(posedge clk) begin
		if (en[28]) begin
			a_s28    <= ta;
			dec_s28  <= ta >= tb;
			diff_s28 <= (ta >= tb) ? ta - tb : tb - ta;
			r_s28    <= r_s27;
			ui_s28   <= ui_s27;
		end
		if (en[29]) begin
			e_s29  <= dec_s28 ? a_s28 - stp[TW+SH-1:SH] : a_s28 + stp[TW+SH-1:SH];
			ui_s29 <= ui_s28;
		end
		if (en[30]) begin
			g_s30 <= e_s29 >> ui_s29;
		end
	end

	// stage 31: normalise by 1/sqrt(2 pi)
	logic [61:0] pg;
	logic [22:0] p_s31;

	assign pg = 62'(g_s30) * 62'(INV_SQRT_2PI_Q32[30:0]);

	always_ff @(posedge clk) begin
		if (en[31]) begin
			p_s31 <= pg[60:38];
		end
	end

	// stage 32 .. 54: divide by sigma, quotient bits 22..0
	logic [22:0] d2_rem_s [0:23];
	logic [22:0] d2_q_s   [0:23];

	assign d2_rem_s[0] = p_s31;
	assign d2_q_s[0]   = '0;

	for (genvar j = 0; j < 23; j++) begin : g_div2
		logic [38:0] dsh;
		logic        ge;
		assign dsh = 39'(s_q) << (22 - j);
		assign ge  = {16'd0, d2_rem_s[j]} >= dsh;
		always_ff @(posedge clk) begin
			if (en[32+j]) begin
				d2_rem_s[j+1] <= ge ? d2_rem_s[j] - dsh[22:0] : d2_rem_s[j];
				d2_q_s[j+1]   <= d2_q_s[j] | (23'(ge) << (22 - j));
			end
		end
	end

	assign mag = d2_q_s[23];

endmodule
